/* hw/rtl/pdsd_pkg.sv */
package pdsd_pkg;

   localparam int CNT_W        = 4;
   localparam int IDX_OUT_W    = 4;
   localparam int PORT_COORD_W = 16;
   localparam int SQ_OUT_W     = 34;
   localparam int HUND_OUT_W   = 24;
   localparam int SCALE_W      = 14;
   localparam int HUND_SCALE   = 10000;

   typedef struct packed {
      logic             valid;
      logic [CNT_W-1:0] count;
   } job_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GEN_RD,
      ST_GEN_SQ,
      ST_GEN_SUM,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_PT_RD,
      ST_ROOT,
      ST_OUT
   } back_state_type;

endpackage

/* hw/rtl/pdsd_ram.sv */
module pdsd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/pdsd_front.sv */
module pdsd_front
   import pdsd_pkg::*;
#(
   parameter int MAX_POINTS = 8,
   parameter int COORD_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [PORT_COORD_W-1:0]    req_coord_x,
   input  logic signed [PORT_COORD_W-1:0]    req_coord_y,
   input  logic signed [PORT_COORD_W-1:0]    req_coord_z,
   input  logic                              req_last_point,
   input  logic                              back_busy,
   input  logic                              job_take,
   output job_type                           job,
   output logic                              pt_wr_en,
   output logic [$clog2(MAX_POINTS)-1:0]     pt_wr_addr,
   output logic [3*COORD_BITS-1:0]           pt_wr_data
);

   localparam int IW = $clog2(MAX_POINTS);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   job_type          job_ff;
   job_type          job_in;
   logic             accept;
   logic             has_room;
   logic [CNT_W-1:0] count_inc;

   assign req_ready = !job_ff.valid && !back_busy;
   assign accept    = req_valid && req_ready;
   assign has_room  = count_ff < CNT_W'(MAX_POINTS);
   assign count_inc = has_room ? count_ff + CNT_W'(1) : count_ff;

   assign pt_wr_en   = accept && has_room;
   assign pt_wr_addr = count_ff[IW-1:0];
   assign pt_wr_data = {COORD_BITS'(req_coord_z), COORD_BITS'(req_coord_y),
                        COORD_BITS'(req_coord_x)};

   always_comb begin
      count_in = count_ff;
      job_in   = job_ff;
      if (job_take) begin
         job_in.valid = 1'b0;
      end
      if (accept) begin
         if (req_last_point) begin
            job_in.valid = 1'b1;
            job_in.count = count_inc;
            count_in     = '0;
         end else begin
            count_in = count_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         job_ff.valid <= 1'b0;
      end else begin
         count_ff     <= count_in;
         job_ff.valid <= job_in.valid;
      end
      job_ff.count <= job_in.count;
   end

   assign job = job_ff;

endmodule

/* hw/rtl/pdsd_isqrt.sv */
module pdsd_isqrt
   import pdsd_pkg::*;
#(
   parameter int DW = 35
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [DW-1:0]                        dist_sq,
   output logic                                 done,
   output logic [(DW + SCALE_W + 1) / 2:0]      result
);

   localparam int ITER = (DW + SCALE_W + 1) / 2;
   localparam int XW   = 2 * ITER;
   localparam int RW   = ITER + 2;
   localparam int CW   = $clog2(ITER + 1);

   logic [XW-1:0]   x_ff, x_in;
   logic [ITER-1:0] root_ff, root_in;
   logic [RW-1:0]   rem_ff, rem_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [RW-1:0]   rem_sh;
   logic [RW-1:0]   trial;

   assign rem_sh = {rem_ff[RW-3:0], x_ff[XW-1 -: 2]};
   assign trial  = {root_ff, 2'b01};

   always_comb begin
      x_in    = x_ff;
      root_in = root_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start && !busy_ff) begin
         x_in    = XW'(dist_sq) * XW'(HUND_SCALE);
         root_in = '0;
         rem_in  = '0;
         cnt_in  = CW'(ITER);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         x_in = {x_ff[XW-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[ITER-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[ITER-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff    <= x_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
   end

   assign done   = done_ff;
   assign result = (ITER + 1)'(root_ff) + (ITER + 1)'(rem_ff > RW'(root_ff));

endmodule

/* hw/rtl/pdsd_back.sv */
module pdsd_back
   import pdsd_pkg::*;
#(
   parameter int MAX_POINTS = 8,
   parameter int COORD_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  job_type                           job,
   output logic                              job_take,
   output logic                              busy,
   output logic [$clog2(MAX_POINTS)-1:0]     pt_rd_addr_a,
   output logic [$clog2(MAX_POINTS)-1:0]     pt_rd_addr_b,
   input  logic [3*COORD_BITS-1:0]           pt_rd_data_a,
   input  logic [3*COORD_BITS-1:0]           pt_rd_data_b,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [IDX_OUT_W-1:0]              rsp_first_index,
   output logic [IDX_OUT_W-1:0]              rsp_second_index,
   output logic signed [PORT_COORD_W-1:0]    rsp_first_x,
   output logic signed [PORT_COORD_W-1:0]    rsp_first_y,
   output logic signed [PORT_COORD_W-1:0]    rsp_first_z,
   output logic signed [PORT_COORD_W-1:0]    rsp_second_x,
   output logic signed [PORT_COORD_W-1:0]    rsp_second_y,
   output logic signed [PORT_COORD_W-1:0]    rsp_second_z,
   output logic [SQ_OUT_W-1:0]               rsp_squared_distance,
   output logic [HUND_OUT_W-1:0]             rsp_distance_hundredths,
   output logic                              rsp_last_pair
);

   localparam int CW    = COORD_BITS;
   localparam int IW    = $clog2(MAX_POINTS);
   localparam int NP    = (MAX_POINTS * (MAX_POINTS - 1)) / 2;
   localparam int PW    = (NP > 1) ? $clog2(NP) : 1;
   localparam int PCW   = $clog2(NP + 1);
   localparam int SQW   = 2 * CW + 2;
   localparam int DW    = 2 * CW + 3;
   localparam int PRW   = DW + 2 * IW;
   localparam int ITER  = (DW + SCALE_W + 1) / 2;

   back_state_type   state_ff, state_in;
   logic [CNT_W-1:0] n_ff, i_ff, k_ff;
   logic [PCW-1:0]   np_ff, p_ff, emitted_ff;
   logic [NP-1:0]    used_ff;
   logic             found_ff;
   logic [DW-1:0]    best_d_ff;
   logic [IW-1:0]    best_i_ff, best_k_ff;
   logic [PW-1:0]    best_p_ff;
   logic [SQW-1:0]   sqx_ff, sqy_ff, sqz_ff;

   logic             gen_done;
   logic             scan_end;
   logic             pr_wr_en;
   logic [PRW-1:0]   pr_rd_data;
   logic [DW-1:0]    pr_d;
   logic [IW-1:0]    pr_i, pr_k;
   logic [DW-1:0]    sum_d;
   logic             sqrt_start, sqrt_done;
   logic [ITER:0]    sqrt_result;
   logic             is_last;

   logic signed [CW-1:0] ax, ay, az, bx, by, bz;
   logic signed [CW:0]   dx, dy, dz;
   logic [CW:0]          adx, ady, adz;

   assign ax = $signed(pt_rd_data_a[CW-1:0]);
   assign ay = $signed(pt_rd_data_a[2*CW-1:CW]);
   assign az = $signed(pt_rd_data_a[3*CW-1:2*CW]);
   assign bx = $signed(pt_rd_data_b[CW-1:0]);
   assign by = $signed(pt_rd_data_b[2*CW-1:CW]);
   assign bz = $signed(pt_rd_data_b[3*CW-1:2*CW]);
   assign dx = (CW + 1)'(ax) - (CW + 1)'(bx);
   assign dy = (CW + 1)'(ay) - (CW + 1)'(by);
   assign dz = (CW + 1)'(az) - (CW + 1)'(bz);
   assign adx = dx[CW] ? (CW + 1)'(-dx) : (CW + 1)'(dx);
   assign ady = dy[CW] ? (CW + 1)'(-dy) : (CW + 1)'(dy);
   assign adz = dz[CW] ? (CW + 1)'(-dz) : (CW + 1)'(dz);
   assign sum_d = DW'(sqx_ff) + DW'(sqy_ff) + DW'(sqz_ff);

   assign pr_d = pr_rd_data[PRW-1 -: DW];
   assign pr_i = pr_rd_data[2*IW-1 -: IW];
   assign pr_k = pr_rd_data[IW-1:0];

   assign gen_done = (k_ff == n_ff - CNT_W'(1)) && (i_ff == n_ff - CNT_W'(2));
   assign scan_end = (p_ff == np_ff - PCW'(1));
   assign is_last  = (emitted_ff == np_ff - PCW'(1));

   pdsd_ram #(.WIDTH(PRW), .DEPTH(NP)) u_pair_ram (
      .clock   (clock),
      .wr_en   (pr_wr_en),
      .wr_addr (np_ff[PW-1:0]),
      .wr_data ({sum_d, i_ff[IW-1:0], k_ff[IW-1:0]}),
      .rd_addr (p_ff[PW-1:0]),
      .rd_data (pr_rd_data)
   );

   pdsd_isqrt #(.DW(DW)) u_isqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (sqrt_start),
      .dist_sq (best_d_ff),
      .done    (sqrt_done),
      .result  (sqrt_result)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (job.valid && job.count >= CNT_W'(2)) begin
               state_in = ST_GEN_RD;
            end
         end
         ST_GEN_RD:   state_in = ST_GEN_SQ;
         ST_GEN_SQ:   state_in = ST_GEN_SUM;
         ST_GEN_SUM:  state_in = gen_done ? ST_SCAN_RD : ST_GEN_RD;
         ST_SCAN_RD:  state_in = ST_SCAN_CMP;
         ST_SCAN_CMP: state_in = scan_end ? ST_PT_RD : ST_SCAN_RD;
         ST_PT_RD:    state_in = ST_ROOT;
         ST_ROOT: begin
            if (sqrt_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               state_in = rsp_last_pair ? ST_IDLE : ST_SCAN_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      job_take     = 1'b0;
      busy         = 1'b1;
      pr_wr_en     = 1'b0;
      sqrt_start   = 1'b0;
      rsp_valid    = 1'b0;
      pt_rd_addr_a = best_i_ff;
      pt_rd_addr_b = best_k_ff;
      case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            job_take = job.valid;
         end
         ST_GEN_RD: begin
            pt_rd_addr_a = i_ff[IW-1:0];
            pt_rd_addr_b = k_ff[IW-1:0];
         end
         ST_GEN_SUM: pr_wr_en   = 1'b1;
         ST_PT_RD:   sqrt_start = 1'b1;
         ST_OUT:     rsp_valid  = 1'b1;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      case (state_ff)
         ST_IDLE: begin
            n_ff       <= job.count;
            i_ff       <= '0;
            k_ff       <= CNT_W'(1);
            np_ff      <= '0;
            p_ff       <= '0;
            found_ff   <= 1'b0;
            emitted_ff <= '0;
            used_ff    <= '0;
         end
         ST_GEN_SQ: begin
            sqx_ff <= SQW'(adx) * SQW'(adx);
            sqy_ff <= SQW'(ady) * SQW'(ady);
            sqz_ff <= SQW'(adz) * SQW'(adz);
         end
         ST_GEN_SUM: begin
            np_ff <= np_ff + PCW'(1);
            if (k_ff == n_ff - CNT_W'(1)) begin
               i_ff <= i_ff + CNT_W'(1);
               k_ff <= i_ff + CNT_W'(2);
            end else begin
               k_ff <= k_ff + CNT_W'(1);
            end
         end
         ST_SCAN_CMP: begin
            if (!used_ff[p_ff[PW-1:0]] && (!found_ff || pr_d > best_d_ff)) begin
               found_ff  <= 1'b1;
               best_d_ff <= pr_d;
               best_i_ff <= pr_i;
               best_k_ff <= pr_k;
               best_p_ff <= p_ff[PW-1:0];
            end
            if (!scan_end) begin
               p_ff <= p_ff + PCW'(1);
            end
         end
         ST_PT_RD: used_ff[best_p_ff] <= 1'b1;
         ST_ROOT: begin
            if (sqrt_done) begin
               rsp_first_index         <= IDX_OUT_W'(best_i_ff);
               rsp_second_index        <= IDX_OUT_W'(best_k_ff);
               rsp_first_x             <= PORT_COORD_W'(ax);
               rsp_first_y             <= PORT_COORD_W'(ay);
               rsp_first_z             <= PORT_COORD_W'(az);
               rsp_second_x            <= PORT_COORD_W'(bx);
               rsp_second_y            <= PORT_COORD_W'(by);
               rsp_second_z            <= PORT_COORD_W'(bz);
               rsp_squared_distance    <= SQ_OUT_W'(best_d_ff);
               rsp_distance_hundredths <= HUND_OUT_W'(sqrt_result);
               rsp_last_pair           <= is_last;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               emitted_ff <= emitted_ff + PCW'(1);
               p_ff       <= '0;
               found_ff   <= 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

/* hw/rtl/pairwise_distance_sort_desc.sv */
// Loading: one point per cycle; req_ready is low while a set is queued or processed.
// After the last point of n, the set is handed to the back end, which reads,
// squares and sums each of the n(n-1)/2 pairs into the pair RAM; then per result
// it runs a max search over the pair RAM, a point read, a bit-serial rounded square
// root and an output stage that holds until rsp_ready.
// Synchronous active-high reset clears the point count, queue and sequencer.
module pairwise_distance_sort_desc
   import pdsd_pkg::*;
#(
   parameter int MAX_POINTS = 8,
   parameter int COORD_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [PORT_COORD_W-1:0] req_coord_x,
   input  logic signed [PORT_COORD_W-1:0] req_coord_y,
   input  logic signed [PORT_COORD_W-1:0] req_coord_z,
   input  logic                           req_last_point,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [IDX_OUT_W-1:0]           rsp_first_index,
   output logic [IDX_OUT_W-1:0]           rsp_second_index,
   output logic signed [PORT_COORD_W-1:0] rsp_first_x,
   output logic signed [PORT_COORD_W-1:0] rsp_first_y,
   output logic signed [PORT_COORD_W-1:0] rsp_first_z,
   output logic signed [PORT_COORD_W-1:0] rsp_second_x,
   output logic signed [PORT_COORD_W-1:0] rsp_second_y,
   output logic signed [PORT_COORD_W-1:0] rsp_second_z,
   output logic [SQ_OUT_W-1:0]            rsp_squared_distance,
   output logic [HUND_OUT_W-1:0]          rsp_distance_hundredths,
   output logic                           rsp_last_pair
);

   localparam int IW = $clog2(MAX_POINTS);
   localparam int PTW = 3 * COORD_BITS;

   job_type        job;
   logic           job_take;
   logic           back_busy;
   logic           pt_wr_en;
   logic [IW-1:0]  pt_wr_addr;
   logic [PTW-1:0] pt_wr_data;
   logic [IW-1:0]  pt_rd_addr_a, pt_rd_addr_b;
   logic [PTW-1:0] pt_rd_data_a, pt_rd_data_b;

   pdsd_front #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_coord_x    (req_coord_x),
      .req_coord_y    (req_coord_y),
      .req_coord_z    (req_coord_z),
      .req_last_point (req_last_point),
      .back_busy      (back_busy),
      .job_take       (job_take),
      .job            (job),
      .pt_wr_en       (pt_wr_en),
      .pt_wr_addr     (pt_wr_addr),
      .pt_wr_data     (pt_wr_data)
   );

   pdsd_ram #(.WIDTH(PTW), .DEPTH(MAX_POINTS)) u_pt_ram_a (
      .clock   (clock),
      .wr_en   (pt_wr_en),
      .wr_addr (pt_wr_addr),
      .wr_data (pt_wr_data),
      .rd_addr (pt_rd_addr_a),
      .rd_data (pt_rd_data_a)
   );

   pdsd_ram #(.WIDTH(PTW), .DEPTH(MAX_POINTS)) u_pt_ram_b (
      .clock   (clock),
      .wr_en   (pt_wr_en),
      .wr_addr (pt_wr_addr),
      .wr_data (pt_wr_data),
      .rd_addr (pt_rd_addr_b),
      .rd_data (pt_rd_data_b)
   );

   pdsd_back #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_back (
      .clock                   (clock),
      .reset                   (reset),
      .job                     (job),
      .job_take                (job_take),
      .busy                    (back_busy),
      .pt_rd_addr_a            (pt_rd_addr_a),
      .pt_rd_addr_b            (pt_rd_addr_b),
      .pt_rd_data_a            (pt_rd_data_a),
      .pt_rd_data_b            (pt_rd_data_b),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_first_index         (rsp_first_index),
      .rsp_second_index        (rsp_second_index),
      .rsp_first_x             (rsp_first_x),
      .rsp_first_y             (rsp_first_y),
      .rsp_first_z             (rsp_first_z),
      .rsp_second_x            (rsp_second_x),
      .rsp_second_y            (rsp_second_y),
      .rsp_second_z            (rsp_second_z),
      .rsp_squared_distance    (rsp_squared_distance),
      .rsp_distance_hundredths (rsp_distance_hundredths),
      .rsp_last_pair           (rsp_last_pair)
   );

   a_no_load_while_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("point load open while a result is pending");

   a_job_not_while_busy: assert property (@(posedge clock) disable iff (reset)
      !(job.valid && back_busy))
      else $error("queued set while back end busy");

   a_last_ends_set: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last_pair) |=> !rsp_valid)
      else $error("result after final pair transfer");

   a_index_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_first_index < rsp_second_index))
      else $error("pair indices out of order");

endmodule
